### hw/rtl/gljust_pkg.sv
// ----------------------------------------------------------------------------
// Greedy line justifier package
// Shared widths, defaults and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gljust_pkg;

    localparam int LEN_W              = 7;   // word length / line width field
    localparam int DEF_MAX_WIDTH      = 64;
    localparam int DEF_MAX_LINE_WORDS = 32;
    localparam logic [LEN_W-1:0] LW_RESET = 7'd64;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;

    // controller -> datapath
    typedef struct packed {
        logic latch;      // capture the accepted word
        logic div_start;  // start gap division for a justified line
        logic rd;         // read buffered word at the emit index
        logic emit;       // load output register with the read word
        logic left;       // current flush is left-justified
        logic emit_ovs;   // load output register with the oversize word
        logic append;     // buffer the captured word
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_ovs;     // offered word is wider than the line
        logic in_flush;   // offered word forces the buffered line out
        logic div_busy;
        logic last_word;  // emit index is on the last buffered word
        logic out_free;   // output register can take a result
        logic cur_ovs;    // captured word is oversize
        logic cur_fin;    // captured word ends the text
    } t_sts;

endpackage

### hw/rtl/gljust_ctrl.sv
// ----------------------------------------------------------------------------
// Greedy line justifier controller
// Sequences accept, gap division, line flush, oversize output and word append.
// ----------------------------------------------------------------------------
module gljust_ctrl import gljust_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV    = 6'b000010,
        S_READ   = 6'b000100,
        S_EMIT   = 6'b001000,
        S_OVS    = 6'b010000,
        S_APPEND = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_left, n_left;
    logic   accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state          = r_state;
        n_left           = r_left;
        o_cmd            = '0;
        o_cmd.latch      = accept;
        o_cmd.div_start  = accept && i_sts.in_flush;
        o_cmd.left       = r_left;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_sts.in_flush) begin
                        n_state = S_DIV;
                        n_left  = 1'b0;
                    end else if (i_sts.in_ovs) begin
                        n_state = S_OVS;
                    end else begin
                        n_state = S_APPEND;
                    end
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_word) begin
                        if (r_left) begin
                            n_state = S_IDLE;
                        end else if (i_sts.cur_ovs) begin
                            n_state = S_OVS;
                        end else begin
                            n_state = S_APPEND;
                        end
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_OVS: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_ovs = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                if (i_sts.cur_fin) begin
                    n_state = S_READ;
                    n_left  = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

endmodule

### hw/rtl/gljust_dp.sv
// ----------------------------------------------------------------------------
// Greedy line justifier datapath
// Line width register, word buffer, fill counters, gap divider and
// the output register.
// ----------------------------------------------------------------------------
module gljust_dp import gljust_pkg::*; #(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int MAX_LINE_WORDS = DEF_MAX_LINE_WORDS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [LEN_W-1:0] i_cfg_data,
    input  logic [LEN_W-1:0] i_word_length,
    input  logic             i_final_word,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             i_m_tready,
    output logic             o_m_tvalid,
    output logic [LEN_W-1:0] o_placed_length,
    output logic [LEN_W-1:0] o_spaces_after,
    output logic             o_line_end,
    output logic             o_oversize,
    output logic             o_run_last
);

    localparam int CNT_W  = $clog2(MAX_LINE_WORDS + 1);
    localparam int IDX_W  = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1;
    localparam int USED_W = LEN_W + 1;
    localparam int DIV_W  = LEN_W + 1;
    localparam int STEP_W = $clog2(LEN_W + 1);
    localparam logic [LEN_W+1:0] MAXW_EXT = (LEN_W + 2)'(MAX_WIDTH);

    logic [LEN_W-1:0]  r_lw;
    logic [LEN_W-1:0]  r_mem [MAX_LINE_WORDS];
    logic [LEN_W-1:0]  r_rd_data;
    logic [CNT_W-1:0]  r_count;
    logic [USED_W-1:0] r_used;
    logic [USED_W-1:0] r_sum;
    logic [CNT_W-1:0]  r_idx;
    logic [LEN_W-1:0]  r_word;
    logic              r_fin;
    logic              r_ovs;
    logic [LEN_W-1:0]  r_dvd;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_out_valid;
    logic [LEN_W-1:0]  r_out_len;
    logic [LEN_W-1:0]  r_out_sp;
    logic              r_out_end;
    logic              r_out_ovs;
    logic              r_out_last;

    logic [LEN_W-1:0]  eff;
    logic              word_ovs;
    logic              over_room;
    logic              full;
    logic [LEN_W-1:0]  spaces;
    logic [USED_W-1:0] taken;
    logic [LEN_W-1:0]  pad;
    logic              last_word;
    logic [LEN_W-1:0]  just_sp;
    logic [LEN_W-1:0]  word_sp;
    logic [DIV_W-1:0]  trial;
    logic              ge;
    logic              out_free;

    // clamp the configured width into 1..MAX_WIDTH
    always_comb begin
        if (r_lw == '0) begin
            eff = LEN_W'(1);
        end else if ({2'b00, r_lw} > MAXW_EXT) begin
            eff = LEN_W'(MAXW_EXT);
        end else begin
            eff = r_lw;
        end
    end

    assign word_ovs  = i_word_length > eff;
    assign over_room = ({1'b0, r_used} + {2'b00, i_word_length}) > {2'b00, eff};
    assign full      = r_count >= CNT_W'(MAX_LINE_WORDS);

    assign spaces = ({1'b0, eff} > r_sum) ? LEN_W'({1'b0, eff} - r_sum) : '0;
    assign taken  = r_used - USED_W'(1);
    assign pad    = ({1'b0, eff} > taken) ? LEN_W'({1'b0, eff} - taken) : '0;

    assign last_word = (r_idx == (r_count - CNT_W'(1)));

    // left-heavy gaps: the first (spaces mod gaps) gaps take one extra space
    always_comb begin
        if (last_word) begin
            just_sp = (r_count == CNT_W'(1)) ? spaces : '0;
        end else if (DIV_W'(r_idx) < r_rem) begin
            just_sp = r_dvd + LEN_W'(1);
        end else begin
            just_sp = r_dvd;
        end
    end

    always_comb begin
        if (i_cmd.left) begin
            word_sp = last_word ? pad : LEN_W'(1);
        end else begin
            word_sp = just_sp;
        end
    end

    assign trial    = {r_rem[DIV_W-2:0], r_dvd[LEN_W-1]};
    assign ge       = trial >= r_dvs;
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        o_sts.in_ovs    = word_ovs;
        o_sts.in_flush  = (r_count != '0) && (word_ovs || over_room || full);
        o_sts.div_busy  = r_busy;
        o_sts.last_word = last_word;
        o_sts.out_free  = out_free;
        o_sts.cur_ovs   = r_ovs;
        o_sts.cur_fin   = r_fin;
    end

    // word buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[r_count[IDX_W-1:0]] <= r_word;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_word <= i_word_length;
            r_fin  <= i_final_word;
            r_ovs  <= word_ovs;
        end
        if (i_cmd.div_start) begin
            r_dvd  <= spaces;
            r_rem  <= '0;
            r_dvs  <= DIV_W'(r_count - CNT_W'(1));
            r_step <= STEP_W'(LEN_W - 1);
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[LEN_W-2:0], ge};
            r_rem  <= ge ? (trial - r_dvs) : trial;
            r_step <= r_step - STEP_W'(1);
        end
        if (i_cmd.emit) begin
            r_out_len  <= r_rd_data;
            r_out_sp   <= word_sp;
            r_out_end  <= last_word;
            r_out_ovs  <= 1'b0;
            r_out_last <= last_word && (i_cmd.left || (!r_ovs && !r_fin));
        end else if (i_cmd.emit_ovs) begin
            r_out_len  <= r_word;
            r_out_sp   <= '0;
            r_out_end  <= 1'b1;
            r_out_ovs  <= 1'b1;
            r_out_last <= 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw        <= LW_RESET;
            r_count     <= '0;
            r_used      <= '0;
            r_sum       <= '0;
            r_idx       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_lw <= i_cfg_data;
            end
            if (i_cmd.div_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy && r_step == '0) begin
                r_busy <= 1'b0;
            end
            if (i_cmd.append) begin
                r_count <= r_count + CNT_W'(1);
                r_used  <= r_used + {1'b0, r_word} + USED_W'(1);
                r_sum   <= r_sum + {1'b0, r_word};
                r_idx   <= '0;
            end else if (i_cmd.emit) begin
                r_idx <= r_idx + CNT_W'(1);
                // line is out: empty the buffer
                if (last_word) begin
                    r_count <= '0;
                    r_used  <= '0;
                    r_sum   <= '0;
                end
            end
            if (i_cmd.emit || i_cmd.emit_ovs) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid      = r_out_valid;
    assign o_placed_length = r_out_len;
    assign o_spaces_after  = r_out_sp;
    assign o_line_end      = r_out_end;
    assign o_oversize      = r_out_ovs;
    assign o_run_last      = r_out_last;

endmodule

### hw/rtl/greedy_line_justifier_top.sv
// ----------------------------------------------------------------------------
// Greedy line justifier
// Packs word lengths into lines of the configured width and emits each word
// with the spaces that follow it.
// ----------------------------------------------------------------------------
// One word at a time. A word that fits in the open line and is not final
// is accepted, then buffered; an oversize word that finds the line empty
// is accepted, then loaded into the output register. When a word closes
// the open line, the line goes out first: a bit-serial gap division, then
// a buffer memory read and an output load for each buffered word, before
// the closing word's own step. A final word that is not oversize is
// buffered, then the last line goes out left-justified, again with a read
// and an output load per word. A stalled output adds its stall to each output
// load. The output register holds the last result of a word while the next
// word is taken. Line width is written on the cfg channel, which is always
// ready; write it only while no word is in progress.
module greedy_line_justifier_top import gljust_pkg::*; #(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int MAX_LINE_WORDS = DEF_MAX_LINE_WORDS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [LEN_W-1:0]       i_cfg_data,     // line_width
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [6:0] word_length, [7] zero
    input  logic                   s_axis_tlast,   // final_word
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [6:0] placed_length,
                                                   // [13:7] spaces_after, [15:14] zero
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [0] line_end, [1] oversize
    output logic                   m_axis_tlast    // run_last
);

    t_cmd             cmd;
    t_sts             sts;
    logic [LEN_W-1:0] placed_length;
    logic [LEN_W-1:0] spaces_after;
    logic             line_end;
    logic             oversize;

    assign o_cfg_ready = 1'b1;

    gljust_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gljust_dp #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_LINE_WORDS (MAX_LINE_WORDS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_word_length   (s_axis_tdata[LEN_W-1:0]),
        .i_final_word    (s_axis_tlast),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_m_tready      (m_axis_tready),
        .o_m_tvalid      (m_axis_tvalid),
        .o_placed_length (placed_length),
        .o_spaces_after  (spaces_after),
        .o_line_end      (line_end),
        .o_oversize      (oversize),
        .o_run_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - 2 * LEN_W){1'b0}}, spaces_after, placed_length};
    assign m_axis_tuser = {oversize, line_end};

endmodule

### hw/rtl/gljust_chk.sv
// ----------------------------------------------------------------------------
// Greedy line justifier port checker
// Watches the top level ports for result ordering and output hold.
// ----------------------------------------------------------------------------
module gljust_chk import gljust_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                   m_axis_tlast
);

    // an oversize word sits alone on its line with no padding
    a_ovs_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tuser[0] && m_axis_tdata[2*LEN_W-1:LEN_W] == '0)
        else $error("oversize result not alone on its line");

    // an oversize word is always the final result of its word
    a_ovs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("oversize result not marked last");

    // while a word still owes results, no new word is taken
    a_no_take_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken while results still pending");

    // a stalled transfer holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output changed");

endmodule

bind greedy_line_justifier_top gljust_chk u_gljust_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
